FILE: rtl/udr_pkg.sv
// Shared constants, types and the CORDIC angle table for the dead-reckoning step.
// Used by udr_cordic and unicycle_dead_reckoning_step; no dependencies.
package udr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 30;
    localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int IDX_W        = 5;

    localparam logic signed [31:0] CORDIC_X0      = 32'sd652032874;
    localparam logic [31:0]        EIGHTH_TURN    = 32'h2000_0000;
    localparam logic signed [32:0] K_SEVEN_TENTHS = 33'sd45875;
    localparam logic signed [32:0] K_HEADING_INC  = 33'sd1093704441;
    localparam logic signed [13:0] RATE_MAX       = 14'sd4096;
    localparam logic signed [13:0] RATE_MIN       = -14'sd4096;

    typedef logic signed [31:0] trig_t;

    typedef struct packed {
        logic  done;
        trig_t sin_val;
        trig_t cos_val;
    } cordic_res_t;

    function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            5'd24:   val = 32'd41;
            5'd25:   val = 32'd20;
            5'd26:   val = 32'd10;
            5'd27:   val = 32'd5;
            5'd28:   val = 32'd3;
            5'd29:   val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/udr_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, sine and cosine in Q2.30.
// Depends on udr_pkg (step count, angle table, result struct).
module udr_cordic
    import udr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] angle,
    output cordic_res_t res
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [1:0]        quad_reg;
    trig_t             x_reg;
    trig_t             y_reg;
    trig_t             z_reg;

    logic [31:0]       shifted;
    trig_t             z_init;
    trig_t             x_sh;
    trig_t             y_sh;
    trig_t             atan_val;
    trig_t             x_next;
    trig_t             y_next;
    trig_t             z_next;
    logic              last_step;

    // Fold the angle to the nearest quarter turn; residual in [-1/8, 1/8) turn.
    assign shifted   = angle + EIGHTH_TURN;
    assign z_init    = $signed({2'b00, shifted[29:0]}) - $signed(EIGHTH_TURN);
    assign x_sh      = x_reg >>> cnt_reg;
    assign y_sh      = y_reg >>> cnt_reg;
    assign atan_val  = $signed(atan_entry(IDX_W'(cnt_reg)));
    assign last_step = (cnt_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        if (!z_reg[31])
        begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - atan_val;
        end
        else
        begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + atan_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= z_init;
            quad_reg <= shifted[31:30];
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // Rotate the result back into its quadrant.
    always_comb
    begin
        res.done = done_reg;
        case (quad_reg)
            2'd0:
            begin
                res.cos_val = x_reg;
                res.sin_val = y_reg;
            end
            2'd1:
            begin
                res.cos_val = -y_reg;
                res.sin_val = x_reg;
            end
            2'd2:
            begin
                res.cos_val = -x_reg;
                res.sin_val = -y_reg;
            end
            default:
            begin
                res.cos_val = y_reg;
                res.sin_val = -x_reg;
            end
        endcase
    end

endmodule

FILE: rtl/unicycle_dead_reckoning_step.sv
// Top level of the unicycle dead-reckoning step: sequencer, shared multiplier, APB registers.
// Depends on udr_pkg and udr_cordic.
//
//  channel | handshake                        | payload
//  --------+----------------------------------+-------------------------------------------
//  in      | in_valid / in_ready              | speed_cmd, turn_rate_cmd, running
//  out     | out_valid / out_ready            | pos_east, pos_north, heading_out,
//          |                                  | quat_z, quat_w
//  apb     | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// A running beat makes both CORDIC passes; a beat with running low makes only the second.
// The single 33x33 multiplier handles speed*0.7, the east and north products and the
// heading increment in the successive states ST_MUL_SPD, ST_MUL_E, ST_MUL_N and ST_MUL_H.
// Reset clears both start registers, the position accumulators and the heading.
// in_ready is high only while the sequencer is idle. A finished result sits in the output
// register; the next beat is taken while it waits, and the sequencer holds in its last
// state only if a second result is ready before the first one has been taken.
module unicycle_dead_reckoning_step
    import udr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] speed_cmd,
    input  logic signed [15:0] turn_rate_cmd,
    input  logic               running,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_east,
    output logic signed [31:0] pos_north,
    output logic [31:0]        heading_out,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CORD1   = 4'd1;
    localparam logic [3:0] ST_MUL_SPD = 4'd2;
    localparam logic [3:0] ST_MUL_E   = 4'd3;
    localparam logic [3:0] ST_MUL_N   = 4'd4;
    localparam logic [3:0] ST_MUL_H   = 4'd5;
    localparam logic [3:0] ST_UPD_H   = 4'd6;
    localparam logic [3:0] ST_CSTART2 = 4'd7;
    localparam logic [3:0] ST_CORD2   = 4'd8;
    localparam logic [3:0] ST_FINISH  = 4'd9;

    localparam logic       REG_START_EAST  = 1'b0;
    localparam logic       REG_START_NORTH = 1'b1;

    logic [3:0]         state_reg;
    logic [3:0]         state_next;

    logic signed [15:0] speed_reg;
    logic signed [13:0] rate_reg;
    logic signed [31:0] start_east_reg;
    logic signed [31:0] start_north_reg;
    logic signed [31:0] east_acc_reg;
    logic signed [31:0] north_acc_reg;
    logic [31:0]        heading_reg;
    logic signed [32:0] kspd_reg;
    logic signed [65:0] prod_reg;
    logic               out_valid_reg;

    logic signed [31:0] pos_east_reg;
    logic signed [31:0] pos_north_reg;
    logic [31:0]        heading_out_reg;
    logic signed [15:0] quat_z_reg;
    logic signed [15:0] quat_w_reg;

    logic               in_beat;
    logic               cfg_wr;
    logic               out_free;
    logic               cord_start;
    logic [31:0]        cord_angle;
    cordic_res_t        cord_res;

    logic signed [13:0] rate_clamped;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] disp_round;
    logic signed [65:0] disp_full;
    logic signed [33:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic signed [31:0] acc_old;
    logic signed [65:0] hinc_round;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    assign pos_east    = pos_east_reg;
    assign pos_north   = pos_north_reg;
    assign heading_out = heading_out_reg;
    assign quat_z      = quat_z_reg;
    assign quat_w      = quat_w_reg;

    assign prdata = (paddr[2] == REG_START_NORTH) ? start_north_reg : start_east_reg;

    // Clamp the turn rate to +-1.0 rad/s in Q4.12.
    always_comb
    begin
        if (turn_rate_cmd > 16'sd4096)
            rate_clamped = RATE_MAX;
        else if (turn_rate_cmd < -16'sd4096)
            rate_clamped = RATE_MIN;
        else
            rate_clamped = turn_rate_cmd[13:0];
    end

    // First pass rotates by the current heading, second pass by half the heading after any update.
    assign cord_start = (in_beat && running) || (state_reg == ST_CSTART2);
    assign cord_angle = (state_reg == ST_CSTART2) ? {1'b0, heading_reg[31:1]} : heading_reg;

    udr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .angle (cord_angle),
        .res   (cord_res)
    );

    // Shared multiplier operand select.
    always_comb
    begin
        case (state_reg)
            ST_MUL_SPD:
            begin
                mul_a = {{17{speed_reg[15]}}, speed_reg};
                mul_b = K_SEVEN_TENTHS;
            end
            ST_MUL_E:
            begin
                mul_a = prod_reg[32:0];
                mul_b = {cord_res.sin_val[31], cord_res.sin_val};
            end
            ST_MUL_N:
            begin
                mul_a = kspd_reg;
                mul_b = {cord_res.cos_val[31], cord_res.cos_val};
            end
            ST_MUL_H:
            begin
                mul_a = {{19{rate_reg[13]}}, rate_reg};
                mul_b = K_HEADING_INC;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round the displacement product by 2^38 (half up) and add with saturation.
    // In ST_MUL_N the product holds the east term, in ST_MUL_H the north term.
    assign acc_old    = (state_reg == ST_MUL_H) ? north_acc_reg : east_acc_reg;
    assign disp_round = prod_reg + (66'sd1 <<< 37);
    assign disp_full  = disp_round >>> 38;
    assign acc_sum    = {{2{acc_old[31]}}, acc_old} + disp_full[33:0];
    assign hinc_round = prod_reg + 66'sd32768;

    always_comb
    begin
        if (acc_sum[33:31] == 3'b000 || acc_sum[33:31] == 3'b111)
            acc_sat = acc_sum[31:0];
        else if (acc_sum[33])
            acc_sat = 32'sh8000_0000;
        else
            acc_sat = 32'sh7FFF_FFFF;
    end

    // Q2.30 to Q2.14 with half-up rounding and clamping to +-1.0.
    function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
        logic signed [32:0] sum;
        logic signed [16:0] r;
        logic signed [15:0] q;
        sum = {v[31], v} + 33'sd32768;
        r   = sum[32:16];
        if (r > 17'sd16384)
            q = 16'sd16384;
        else if (r < -17'sd16384)
            q = -16'sd16384;
        else
            q = r[15:0];
        return q;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                    state_next = running ? ST_CORD1 : ST_CSTART2;
            end
            ST_CORD1:
            begin
                if (cord_res.done)
                    state_next = ST_MUL_SPD;
            end
            ST_MUL_SPD: state_next = ST_MUL_E;
            ST_MUL_E:   state_next = ST_MUL_N;
            ST_MUL_N:   state_next = ST_MUL_H;
            ST_MUL_H:   state_next = ST_UPD_H;
            ST_UPD_H:   state_next = ST_CSTART2;
            ST_CSTART2: state_next = ST_CORD2;
            ST_CORD2:
            begin
                if (cord_res.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            start_east_reg  <= '0;
            start_north_reg <= '0;
            east_acc_reg    <= '0;
            north_acc_reg   <= '0;
            heading_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // A preset write also loads the matching accumulator.
            if (cfg_wr)
            begin
                if (paddr[2] == REG_START_EAST)
                begin
                    start_east_reg <= pwdata;
                    east_acc_reg   <= pwdata;
                end
                else
                begin
                    start_north_reg <= pwdata;
                    north_acc_reg   <= pwdata;
                end
            end

            if (state_reg == ST_MUL_N)
                east_acc_reg <= acc_sat;
            if (state_reg == ST_MUL_H)
                north_acc_reg <= acc_sat;
            if (state_reg == ST_UPD_H)
                heading_reg <= heading_reg + hinc_round[47:16];

            if (state_reg == ST_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            speed_reg <= speed_cmd;
            rate_reg  <= rate_clamped;
        end
        prod_reg <= mul_a * mul_b;
        if (state_reg == ST_MUL_E)
            kspd_reg <= prod_reg[32:0];
        if (state_reg == ST_FINISH && out_free)
        begin
            pos_east_reg    <= east_acc_reg;
            pos_north_reg   <= north_acc_reg;
            heading_out_reg <= heading_reg;
            quat_z_reg      <= to_q14(cord_res.sin_val);
            quat_w_reg      <= to_q14(cord_res.cos_val);
        end
    end

    // The CORDIC only finishes while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cord_res.done |-> (state_reg == ST_CORD1 || state_reg == ST_CORD2))
        else $error("CORDIC finished outside a wait state");

    // An accepted beat always starts a CORDIC pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_CORD1 || state_reg == ST_CSTART2))
        else $error("accepted beat did not start the sequencer");

    // A result never overwrites one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !out_ready) |=> state_reg == ST_FINISH)
        else $error("sequencer left FINISH while output was blocked");

    // The heading only moves in its update state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_UPD_H) |=> $stable(heading_reg))
        else $error("heading changed outside its update state");

endmodule
